// ===== sv/imm8_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm8_pkg
// Shared sizes, command codes and sequencer states of the 32-bit integer
// matrix multiply core.
// ----------------------------------------------------------------------------
package imm8_pkg;

   // matrix size and derived widths
   localparam int unsigned DIM    = 8;
   localparam int unsigned IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int unsigned ADDR_W = $clog2(DIM * DIM);

   // beat field widths
   localparam int unsigned CMD_W  = 2;
   localparam int unsigned ROW_W  = 3;
   localparam int unsigned COL_W  = 3;
   localparam int unsigned DATA_W = 32;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_OUTPUT
   } state_type;

endpackage

// ===== sv/imm8_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm8 channel interfaces
// Valid/ready channels for request beats (loads and compute) and for
// product element beats.
// ----------------------------------------------------------------------------
interface imm8_req_if
   import imm8_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic [ROW_W-1:0]         row;
   logic [COL_W-1:0]         col;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output cmd, output row, output col, output value,
                   input ready);
   modport sink   (input valid, input cmd, input row, input col, input value,
                   output ready);
endinterface

interface imm8_rsp_if
   import imm8_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic [ROW_W-1:0]         out_row;
   logic [COL_W-1:0]         out_col;
   logic signed [DATA_W-1:0] product_value;
   logic                     last;

   modport source (output valid, output out_row, output out_col,
                   output product_value, output last, input ready);
   modport sink   (input valid, input out_row, input out_col,
                   input product_value, input last, output ready);
endinterface

// ===== sv/int32_matrix_multiply_8x8_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int32_matrix_multiply_8x8_core
// Signed 32-bit square matrix product C = A x B with one shared multiplier.
// ----------------------------------------------------------------------------
// Usage
//   req: one beat per command. Load A / load B write one element at row/col
//   (out-of-range indices and unused codes are dropped). A compute beat
//   streams all DIM*DIM elements of C on rsp in row-major order, each the
//   dot product wrapped modulo 2^32, with last set on the final element.
//   Loads leave the sequencer idle, so req stays ready for the next beat.
//   Compute: each element issues reads of both matrices along the dot product,
//   drains the read/multiply/accumulate pipe and holds the element on rsp
//   until it is taken. The single 32x32 multiplier and one read port per
//   matrix memory bound the compute throughput.
//   req is held low from the compute beat until the last element is taken.
//   A stalled rsp beat holds its payload; the sequencer waits on it.
//   Reset returns the sequencer to idle; matrix contents are not cleared and
//   must be loaded before a compute uses them.
// ----------------------------------------------------------------------------
module int32_matrix_multiply_8x8_core
   import imm8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   imm8_req_if.sink    req,
   imm8_rsp_if.source  rsp
);

   // sequencer state and counters
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   r_ff, r_in;
   logic [IDX_W-1:0]   c_ff, c_in;
   logic [IDX_W-1:0]   k_ff, k_in;

   // datapath pipe
   logic               rd_vld_ff;
   logic               prod_vld_ff;
   logic [DATA_W-1:0]  a_rd_ff;
   logic [DATA_W-1:0]  b_rd_ff;
   logic [DATA_W-1:0]  prod_ff;
   logic [DATA_W-1:0]  acc_ff, acc_in;
   logic [DATA_W-1:0]  mul_lo;

   // matrix memories
   logic [DATA_W-1:0]  mem_a [DIM*DIM];
   logic [DATA_W-1:0]  mem_b [DIM*DIM];

   logic               req_beat;
   logic               rsp_beat;
   logic               in_range;
   logic               is_last;
   logic               wr_a, wr_b;
   logic               rd_en;
   logic               acc_clr;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  a_addr;
   logic [ADDR_W-1:0]  b_addr;

   // handshakes
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUTPUT);
   assign req_beat  = req.valid && req.ready;
   assign rsp_beat  = rsp.valid && rsp.ready;

   // addressing
   assign in_range = (32'(req.row) < DIM) && (32'(req.col) < DIM);
   assign wr_addr  = ADDR_W'(ADDR_W'(req.row) * ADDR_W'(DIM) + ADDR_W'(req.col));
   assign a_addr   = ADDR_W'(ADDR_W'(r_ff) * ADDR_W'(DIM) + ADDR_W'(k_ff));
   assign b_addr   = ADDR_W'(ADDR_W'(k_ff) * ADDR_W'(DIM) + ADDR_W'(c_ff));
   assign is_last  = (r_ff == IDX_W'(DIM - 1)) && (c_ff == IDX_W'(DIM - 1));

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         r_ff        <= '0;
         c_ff        <= '0;
         k_ff        <= '0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         r_ff        <= r_in;
         c_ff        <= c_in;
         k_ff        <= k_in;
         rd_vld_ff   <= rd_en;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   // next state and control
   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      k_in     = k_ff;
      wr_a     = 1'b0;
      wr_b     = 1'b0;
      rd_en    = 1'b0;
      acc_clr  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               case (req.cmd)
                  CMD_LOAD_A: wr_a = in_range;
                  CMD_LOAD_B: wr_b = in_range;
                  CMD_COMPUTE: begin
                     state_in = ST_ISSUE;
                     r_in     = '0;
                     c_in     = '0;
                     k_in     = '0;
                     acc_clr  = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_ISSUE: begin
            // one A/B read pair per cycle along the dot product
            rd_en = 1'b1;
            if (k_ff == IDX_W'(DIM - 1)) begin
               k_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (rsp_beat) begin
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  if (c_ff == IDX_W'(DIM - 1)) begin
                     c_in = '0;
                     r_in = r_ff + 1'b1;
                  end else begin
                     c_in = c_ff + 1'b1;
                  end
                  acc_clr  = 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // matrix memories, registered read
   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[wr_addr] <= req.value;
      end
      if (wr_b) begin
         mem_b[wr_addr] <= req.value;
      end
      if (rd_en) begin
         a_rd_ff <= mem_a[a_addr];
         b_rd_ff <= mem_b[b_addr];
      end
   end

   // shared multiplier, low word only
   assign mul_lo = a_rd_ff * b_rd_ff;

   // accumulate wraps modulo 2^32
   always_comb begin
      acc_in = acc_ff;
      if (acc_clr) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         prod_ff <= mul_lo;
      end
      acc_ff <= acc_in;
   end

   // result beat
   assign rsp.out_row       = ROW_W'(r_ff);
   assign rsp.out_col       = COL_W'(c_ff);
   assign rsp.product_value = $signed(acc_ff);
   assign rsp.last          = is_last;

endmodule

// ===== sv/imm8_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imm8_checker
// Port-level checks of the matrix multiply core, bound to the core module.
// ----------------------------------------------------------------------------
module imm8_checker
   import imm8_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [ROW_W-1:0]         rsp_out_row,
   input logic [COL_W-1:0]         rsp_out_col,
   input logic signed [DATA_W-1:0] rsp_product_value,
   input logic                     rsp_last
);

   // a stalled result beat stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // a stalled result beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_row) && $stable(rsp_out_col)
         && $stable(rsp_product_value) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   // no request is taken while a product is streaming out
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req ready while rsp beat pending");

   // the final element frees the request side, others start a new dot product
   a_last_frees_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready && !rsp_valid)
      else $error("req not ready after last beat");

   a_gap_between_elems: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> !rsp_valid && !req_ready)
      else $error("element beat followed too early");

endmodule

bind int32_matrix_multiply_8x8_core imm8_checker u_imm8_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_out_row       (rsp.out_row),
   .rsp_out_col       (rsp.out_col),
   .rsp_product_value (rsp.product_value),
   .rsp_last          (rsp.last)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 8x8 signed 32-bit matrix multiply core. Both
// matrices are first zero-filled so that no unwritten element is ever read.
// A table of directed request beats follows, then constrained-free random
// loads and computes. Product beats are checked field by field against an
// in-bench predictor; random idling on both channels plus one long response
// hold-off exercise back-pressure.
// ----------------------------------------------------------------------------
module tb_top
   import imm8_pkg::*;
   ;

   // unused command code, dropped by the core
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int DIR_ROWS     = 20;
   localparam int RAND_BEATS   = 62;
   localparam int IDLE_PCT     = 31;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE_CYCLES = 2 * (DIM + 4);

   // one product element beat
   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [DATA_W-1:0] value;
      logic              last;
   } product_beat_type;

   // one directed request row; fixed marks a product whose every element
   // equals fixed_value
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [DATA_W-1:0] value;
      logic              fixed;
      logic [DATA_W-1:0] fixed_value;
   } req_row_type;

   logic clock;
   logic reset;

   imm8_req_if req_ch ();
   imm8_rsp_if rsp_ch ();

   int32_matrix_multiply_8x8_core u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // predictor copy of both matrices
   logic [DATA_W-1:0] elem_a [DIM*DIM];
   logic [DATA_W-1:0] elem_b [DIM*DIM];

   product_beat_type product_expect_q [$];
   req_row_type      dir_tab [DIR_ROWS];

   int  fail_count  = 0;
   bit  steady_flow = 1'b0;
   bit  hold_rsp    = 1'b0;

   // clock, 2 ns period
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // dot product of a row of A and a column of B, wrapped to 32 bits
   function automatic logic [DATA_W-1:0] dot_product(input int r, input int c);
      logic [DATA_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
         acc = acc + elem_a[r*DIM+k] * elem_b[k*DIM+c];
      end
      return acc;
   endfunction

   // update the matrices or queue the whole product for an accepted beat
   function automatic void predict_request(input req_row_type rq);
      product_beat_type pb;
      case (rq.cmd)
         CMD_LOAD_A: begin
            if (rq.row < DIM && rq.col < DIM) elem_a[rq.row*DIM+rq.col] = rq.value;
         end
         CMD_LOAD_B: begin
            if (rq.row < DIM && rq.col < DIM) elem_b[rq.row*DIM+rq.col] = rq.value;
         end
         CMD_COMPUTE: begin
            for (int r = 0; r < DIM; r++) begin
               for (int c = 0; c < DIM; c++) begin
                  pb.row   = ROW_W'(r);
                  pb.col   = COL_W'(c);
                  pb.value = rq.fixed ? rq.fixed_value : dot_product(r, c);
                  pb.last  = (r == DIM - 1) && (c == DIM - 1);
                  product_expect_q.push_back(pb);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // mostly full-range values, with a good share of extremes and small ones
   function automatic logic [DATA_W-1:0] rand_element();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         4:       return 32'($signed($urandom_range(0, 15)) - 8);
         default: return $urandom;
      endcase
   endfunction

   // drive one request beat at the falling edge, hold it until taken
   task automatic send_request(input req_row_type rq);
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.cmd   = rq.cmd;
      req_ch.row   = rq.row;
      req_ch.col   = rq.col;
      req_ch.value = rq.value;
      do @(posedge clock); while (!req_ch.ready);
      predict_request(rq);
      @(negedge clock);
   endtask

   // stimulus: zero fill, directed table, random beats, then drain
   initial begin : stimulus
      req_row_type rq;
      int       counted;
      int       pick;

      req_ch.valid = 1'b0;
      req_ch.cmd   = CMD_LOAD_A;
      req_ch.row   = '0;
      req_ch.col   = '0;
      req_ch.value = '0;
      reset        = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero every element of both matrices so no compute reads stale data
      rq = '0;
      for (int i = 0; i < 2 * DIM * DIM; i++) begin
         rq.cmd = (i < DIM * DIM) ? CMD_LOAD_A : CMD_LOAD_B;
         rq.row = ROW_W'((i % (DIM * DIM)) / DIM);
         rq.col = COL_W'(i % DIM);
         send_request(rq);
      end

      // directed rows
      dir_tab = '{
         '{CMD_COMPUTE, 3'd0, 3'd0, 32'h0000_0000, 1'b1, 32'h0000_0000},
         '{CMD_UNUSED,  3'd7, 3'd7, 32'h7fff_ffff, 1'b0, 32'h0000_0000},
         '{CMD_UNUSED,  3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0000_0000},
         '{CMD_COMPUTE, 3'd7, 3'd7, 32'hffff_ffff, 1'b1, 32'h0000_0000},
         '{CMD_LOAD_A,  3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0000_0000},
         '{CMD_LOAD_B,  3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0000_0000},
         // min times min wraps to zero
         '{CMD_COMPUTE, 3'd0, 3'd0, 32'h0000_0000, 1'b1, 32'h0000_0000},
         '{CMD_LOAD_A,  3'd7, 3'd7, 32'hffff_ffff, 1'b0, 32'h0000_0000},
         '{CMD_LOAD_B,  3'd7, 3'd7, 32'hffff_ffff, 1'b0, 32'h0000_0000},
         '{CMD_COMPUTE, 3'd0, 3'd0, 32'h0000_0000, 1'b0, 32'h0000_0000},
         '{CMD_LOAD_A,  3'd0, 3'd7, 32'h7fff_ffff, 1'b0, 32'h0000_0000},
         '{CMD_LOAD_B,  3'd7, 3'd0, 32'h7fff_ffff, 1'b0, 32'h0000_0000},
         '{CMD_LOAD_A,  3'd5, 3'd2, 32'h5555_5555, 1'b0, 32'h0000_0000},
         '{CMD_LOAD_B,  3'd2, 3'd5, 32'haaaa_aaaa, 1'b0, 32'h0000_0000},
         '{CMD_LOAD_A,  3'd2, 3'd5, 32'haaaa_aaaa, 1'b0, 32'h0000_0000},
         '{CMD_LOAD_B,  3'd5, 3'd2, 32'h5555_5555, 1'b0, 32'h0000_0000},
         '{CMD_LOAD_A,  3'd3, 3'd4, 32'h0000_0001, 1'b0, 32'h0000_0000},
         '{CMD_LOAD_B,  3'd4, 3'd3, 32'h7fff_ffff, 1'b0, 32'h0000_0000},
         '{CMD_COMPUTE, 3'd0, 3'd0, 32'h0000_0000, 1'b0, 32'h0000_0000},
         // repeated compute with junk in the ignored fields
         '{CMD_COMPUTE, 3'd6, 3'd1, 32'hdead_beef, 1'b0, 32'h0000_0000}
      };
      for (int i = 0; i < DIR_ROWS; i++) begin
         send_request(dir_tab[i]);
      end

      // random loads and computes; the first product is held off at the sink
      hold_rsp = 1'b1;
      counted  = 0;
      while (counted < RAND_BEATS) begin
         steady_flow = (counted >= 20) && (counted < 45);
         rq          = '0;
         rq.row      = ROW_W'($urandom_range(0, 7));
         rq.col      = COL_W'($urandom_range(0, 7));
         rq.value    = rand_element();
         pick        = $urandom_range(0, 99);
         if (pick < 5 || counted == RAND_BEATS - 1) begin
            rq.cmd = CMD_COMPUTE;
         end else if (pick < 9) begin
            rq.cmd = CMD_UNUSED;
         end else if (pick < 54) begin
            rq.cmd = CMD_LOAD_A;
         end else begin
            rq.cmd = CMD_LOAD_B;
         end
         send_request(rq);
         if (rq.cmd != CMD_UNUSED) counted++;
      end
      steady_flow  = 1'b0;
      req_ch.valid = 1'b0;

      // drain outstanding products, then let the pipe settle
      while (product_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // product sink: random stalls, one long hold-off while requests queue up
   initial begin : product_sink
      rsp_ch.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_rsp && rsp_ch.valid) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_ch.ready = steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // compare each taken product beat with the oldest expectation
   always @(posedge clock) begin : product_check
      product_beat_type exp_beat;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (product_expect_q.size() == 0) begin
            $error("product beat with nothing expected: row %0d col %0d value %0d",
                   rsp_ch.out_row, rsp_ch.out_col, rsp_ch.product_value);
            fail_count++;
         end else begin
            exp_beat = product_expect_q.pop_front();
            if (rsp_ch.out_row !== exp_beat.row) begin
               $error("out_row: expected %0d, actual %0d", exp_beat.row, rsp_ch.out_row);
               fail_count++;
            end
            if (rsp_ch.out_col !== exp_beat.col) begin
               $error("out_col: expected %0d, actual %0d", exp_beat.col, rsp_ch.out_col);
               fail_count++;
            end
            if (rsp_ch.product_value !== exp_beat.value) begin
               $error("product_value: expected %0d, actual %0d",
                      $signed(exp_beat.value), rsp_ch.product_value);
               fail_count++;
            end
            if (rsp_ch.last !== exp_beat.last) begin
               $error("last: expected %0b, actual %0b", exp_beat.last, rsp_ch.last);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
